// ===== src/sfd_pkg.sv =====
`timescale 1ns / 1ps

package sfd_pkg;

  // default sizing
  localparam int unsigned POINTS_DEF          = 90;
  localparam int unsigned MAX_FRAME_BYTES_DEF = 4096;

  // frame markers, oldest byte first
  localparam logic [7:0] HDR_BYTES [4] = '{8'h01, 8'h02, 8'h03, 8'h04};
  localparam logic [23:0] HDR_LEAD    = 24'h010203;
  localparam logic [7:0]  HDR_LAST    = 8'h04;
  localparam logic [23:0] FTR_LEAD    = 24'h403020;
  localparam logic [7:0]  FTR_LAST    = 8'h10;

  // fixed odometry layout
  localparam logic [17:0] ODO_LCOUNT_END = 18'h0f;
  localparam logic [17:0] ODO_RCOUNT_END = 18'h13;
  localparam logic [17:0] ODO_LSPEED_END = 18'h15;
  localparam logic [17:0] ODO_RECORD_END = 18'h17;

  // configuration reset values
  localparam logic [7:0]  TYPE_OFFSET_RST  = 8'd10;
  localparam logic [15:0] LASER_CODE_RST   = 16'd0;
  localparam logic [15:0] ODOM_CODE_RST    = 16'd1;
  localparam logic [7:0]  INDEX_OFFSET_RST = 8'd12;
  localparam logic [7:0]  DATA_OFFSET_RST  = 8'd16;

  localparam int unsigned CFG_ADDR_W = 5;

  // register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_TYPE_OFFSET  = 3'd0,
    REG_LASER_CODE   = 3'd1,
    REG_ODOM_CODE    = 3'd2,
    REG_INDEX_OFFSET = 3'd3,
    REG_DATA_OFFSET  = 3'd4
  } reg_idx_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_POINT     = 2'd0,
    KIND_ODOM      = 2'd1,
    KIND_FRAME_END = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         angle;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic               point_valid;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic               frame_ok;
    logic [15:0]        frame_kind;
  } res_t;

  // fields captured from frame bytes
  typedef struct packed {
    logic [15:0] cur_type;
    logic [9:0]  start_index;
    logic [23:0] point_asm;
    logic [31:0] left_count;
    logic [31:0] right_count;
    logic [15:0] left_speed;
  } cap_t;

endpackage

// ===== src/sensor_frame_deframer.sv =====
`timescale 1ns / 1ps

// Sensor frame deframer.
// The in_ channel takes one raw link byte per request (in_data_byte). The
// block tracks the last bytes seen, restarts a frame on the header
// 01 02 03 04 and closes it on the footer 40 30 20 10, which always gives a
// frame-end request on the out_ channel. Laser frames give one point request
// per completed four-byte point, odometry frames one record request.
// Offsets and type codes are set over the APB-style port (psel .. pready),
// to be written by the user only while the block is idle, which the block
// itself does not enforce; pready is tied high. Throughput: one byte per
// cycle while in_stall is low. All decoding is a single pass of compares
// and byte captures between the frame state registers and a two-entry
// result buffer. A result request is offered the cycle after its byte is
// accepted, unless earlier results still wait. When the receiver stalls,
// results queue in the two-entry buffer and the input keeps flowing until
// both entries are full; then in_stall rises until the receiver takes one.
// Reset (rst_n low, synchronous) loads the register defaults, clears all
// frame state and empties the result buffer.
module sensor_frame_deframer #(
  parameter int unsigned POINTS          = sfd_pkg::POINTS_DEF,
  parameter int unsigned MAX_FRAME_BYTES = sfd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // byte input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_data_byte,
  // results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_kind,
  output logic [9:0]                      out_angle,
  output logic signed [15:0]              out_coord_x,
  output logic signed [15:0]              out_coord_y,
  output logic                            out_point_valid,
  output logic signed [31:0]              out_left_count,
  output logic signed [31:0]              out_right_count,
  output logic signed [15:0]              out_left_speed,
  output logic signed [15:0]              out_right_speed,
  output logic                            out_frame_ok,
  output logic [15:0]                     out_frame_kind,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int unsigned POS_W    = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [17:0] DATA_LEN = 18'(4 * POINTS);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

  // configuration registers
  logic [7:0]  type_offset_r, index_offset_r, data_offset_r;
  logic [15:0] laser_code_r, odom_code_r;

  // frame state
  logic [23:0]       recent_r, recent_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              hdr_seen_r, hdr_seen_nxt;
  sfd_pkg::cap_t     cap_r, cap_nxt;

  // result buffer
  sfd_pkg::res_t     buf_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        cnt_r;

  logic              in_acc, push, pop, has_res;
  sfd_pkg::res_t     res;
  sfd_pkg::cap_t     cap_byte, cap_hdr;
  logic [17:0]       pos18, rel;
  logic [15:0]       y_raw;

  // one byte of capture at frame position p, r holds the three bytes before
  function automatic sfd_pkg::cap_t capture(
    input sfd_pkg::cap_t c,
    input logic [17:0]   p,
    input logic [7:0]    b,
    input logic [23:0]   r,
    input logic [7:0]    t_off,
    input logic [7:0]    i_off,
    input logic [7:0]    d_off
  );
    sfd_pkg::cap_t o;
    logic [17:0]   rl;
    o  = c;
    rl = p - 18'(d_off);
    if (p == 18'(t_off))         o.cur_type[7:0]    = b;
    if (p == 18'(t_off) + 18'd1) o.cur_type[15:8]   = b;
    if (p == 18'(i_off))         o.start_index[7:0] = b;
    if (p == 18'(i_off) + 18'd1) o.start_index[9:8] = b[1:0];
    if (p >= 18'(d_off) && rl < DATA_LEN) begin
      if (rl[1:0] == 2'd1) o.point_asm = {8'h00, b, r[7:0]};
      else if (rl[1:0] == 2'd2) o.point_asm[23:16] = b;
    end
    if (p == sfd_pkg::ODO_LCOUNT_END) o.left_count  = {b, r[7:0], r[15:8], r[23:16]};
    if (p == sfd_pkg::ODO_RCOUNT_END) o.right_count = {b, r[7:0], r[15:8], r[23:16]};
    if (p == sfd_pkg::ODO_LSPEED_END) o.left_speed  = {b, r[7:0]};
    return o;
  endfunction

  // magnitude below 512 for a 16-bit signed value
  function automatic logic small_mag(input logic [15:0] v);
    return (v[15:9] == 7'h00) || (v[15:9] == 7'h7f && v[8:0] != 9'h000);
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (cnt_r == 2'd2);
  assign pop      = out_valid && !out_stall;
  assign push     = in_acc && has_res;
  assign pos18    = 18'(pos_r);
  assign rel      = pos18 - 18'(data_offset_r);

  // header bytes replayed as frame bytes 0 to 3 from a cleared frame
  always_comb begin
    logic [23:0] prev;
    cap_hdr = '0;
    prev    = '0;
    for (int p = 0; p < 4; p++) begin
      cap_hdr = capture(cap_hdr, 18'(p), sfd_pkg::HDR_BYTES[p], prev,
                        type_offset_r, index_offset_r, data_offset_r);
      prev    = {prev[15:0], sfd_pkg::HDR_BYTES[p]};
    end
  end

  // capture for an ordinary frame byte
  assign cap_byte = capture(cap_r, pos18, in_data_byte, recent_r,
                            type_offset_r, index_offset_r, data_offset_r);
  assign y_raw    = {in_data_byte, cap_byte.point_asm[23:16]};

  // frame decode
  always_comb begin
    recent_nxt   = {recent_r[15:0], in_data_byte};
    pos_nxt      = pos_r;
    hdr_seen_nxt = hdr_seen_r;
    cap_nxt      = cap_r;
    res          = '0;
    has_res      = 1'b0;
    if (pos18 >= 18'd3 && recent_r == sfd_pkg::FTR_LEAD &&
        in_data_byte == sfd_pkg::FTR_LAST) begin
      // footer: report and clear the frame
      res.kind       = sfd_pkg::KIND_FRAME_END;
      res.frame_ok   = hdr_seen_r;
      res.frame_kind = cap_r.cur_type;
      has_res        = 1'b1;
      recent_nxt     = '0;
      pos_nxt        = '0;
      hdr_seen_nxt   = 1'b0;
      cap_nxt        = '0;
    end else if (pos18 >= 18'd3 && recent_r == sfd_pkg::HDR_LEAD &&
                 in_data_byte == sfd_pkg::HDR_LAST) begin
      // header: restart with the header as the first four bytes
      recent_nxt   = {sfd_pkg::HDR_BYTES[1], sfd_pkg::HDR_BYTES[2], sfd_pkg::HDR_BYTES[3]};
      pos_nxt      = POS_W'(4);
      hdr_seen_nxt = 1'b1;
      cap_nxt      = cap_hdr;
    end else if (pos_r < POS_MAX) begin
      cap_nxt = cap_byte;
      pos_nxt = pos_r + POS_W'(1);
      if (hdr_seen_r) begin
        if (cap_byte.cur_type == laser_code_r && pos18 >= 18'(data_offset_r) &&
            rel < DATA_LEN && rel[1:0] == 2'd3) begin
          // completed laser point
          res.kind        = sfd_pkg::KIND_POINT;
          res.angle       = cap_byte.start_index + {3'b000, rel[8:2]};
          res.coord_x     = cap_byte.point_asm[15:0];
          res.coord_y     = y_raw;
          res.point_valid = small_mag(cap_byte.point_asm[15:0]) && small_mag(y_raw);
          res.frame_kind  = cap_byte.cur_type;
          has_res         = 1'b1;
        end else if (cap_byte.cur_type == odom_code_r &&
                     pos18 == sfd_pkg::ODO_RECORD_END) begin
          // odometry record
          res.kind        = sfd_pkg::KIND_ODOM;
          res.left_count  = cap_byte.left_count;
          res.right_count = cap_byte.right_count;
          res.left_speed  = cap_byte.left_speed;
          res.right_speed = {in_data_byte, recent_r[7:0]};
          res.frame_kind  = cap_byte.cur_type;
          has_res         = 1'b1;
        end
      end
    end
  end

  // frame state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r       <= '0;
      pos_r          <= '0;
      hdr_seen_r     <= 1'b0;
      cap_r          <= '0;
      type_offset_r  <= sfd_pkg::TYPE_OFFSET_RST;
      laser_code_r   <= sfd_pkg::LASER_CODE_RST;
      odom_code_r    <= sfd_pkg::ODOM_CODE_RST;
      index_offset_r <= sfd_pkg::INDEX_OFFSET_RST;
      data_offset_r  <= sfd_pkg::DATA_OFFSET_RST;
    end else begin
      if (in_acc) begin
        recent_r   <= recent_nxt;
        pos_r      <= pos_nxt;
        hdr_seen_r <= hdr_seen_nxt;
        cap_r      <= cap_nxt;
      end
      if (psel && penable && pwrite) begin
        case (sfd_pkg::reg_idx_t'(paddr[4:2]))
          sfd_pkg::REG_TYPE_OFFSET:  type_offset_r  <= pwdata[7:0];
          sfd_pkg::REG_LASER_CODE:   laser_code_r   <= pwdata[15:0];
          sfd_pkg::REG_ODOM_CODE:    odom_code_r    <= pwdata[15:0];
          sfd_pkg::REG_INDEX_OFFSET: index_offset_r <= pwdata[7:0];
          sfd_pkg::REG_DATA_OFFSET:  data_offset_r  <= pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // register readback
  always_comb begin
    case (sfd_pkg::reg_idx_t'(paddr[4:2]))
      sfd_pkg::REG_TYPE_OFFSET:  prdata = {24'h0, type_offset_r};
      sfd_pkg::REG_LASER_CODE:   prdata = {16'h0, laser_code_r};
      sfd_pkg::REG_ODOM_CODE:    prdata = {16'h0, odom_code_r};
      sfd_pkg::REG_INDEX_OFFSET: prdata = {24'h0, index_offset_r};
      sfd_pkg::REG_DATA_OFFSET:  prdata = {24'h0, data_offset_r};
      default:                   prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // two-entry result buffer pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // result buffer storage
  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= res;
  end

  assign out_valid       = (cnt_r != 2'd0);
  assign out_kind        = buf_r[rd_ptr_r].kind;
  assign out_angle       = buf_r[rd_ptr_r].angle;
  assign out_coord_x     = buf_r[rd_ptr_r].coord_x;
  assign out_coord_y     = buf_r[rd_ptr_r].coord_y;
  assign out_point_valid = buf_r[rd_ptr_r].point_valid;
  assign out_left_count  = buf_r[rd_ptr_r].left_count;
  assign out_right_count = buf_r[rd_ptr_r].right_count;
  assign out_left_speed  = buf_r[rd_ptr_r].left_speed;
  assign out_right_speed = buf_r[rd_ptr_r].right_speed;
  assign out_frame_ok    = buf_r[rd_ptr_r].frame_ok;
  assign out_frame_kind  = buf_r[rd_ptr_r].frame_kind;

endmodule
